[rtl/core/wdiv_pkg.sv]
// wdiv_pkg: shared types and constants of the window downsample inverse variance core
`default_nettype none
package wdiv_pkg;

  localparam int unsigned DIM        = 3;
  localparam int unsigned ELEM_W     = 2;
  localparam int unsigned CNT_W      = 16;
  localparam logic [CNT_W-1:0] MAX_WINDOW = 16'd65535;
  localparam logic [31:0] PERIOD_RESET = 32'd1000;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned INFO_W     = 64;
  localparam int unsigned QUO_W      = 49;
  localparam logic [31:0] MASK32     = 32'hFFFF_FFFF;
  localparam logic [QUO_W-1:0] ONE_Q48   = {1'b1, 48'd0};
  localparam logic [QUO_W-1:0] RECIP_SAT = {QUO_W{1'b1}};

  typedef struct packed {
    logic [31:0]        timestamp;
    logic signed [31:0] mean_0;
    logic signed [31:0] mean_1;
    logic signed [31:0] mean_2;
    logic [31:0]        var_0;
    logic [31:0]        var_1;
    logic [31:0]        var_2;
    logic               is_final_time;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        out_timestamp;
    logic signed [31:0] avg_0;
    logic signed [31:0] avg_1;
    logic signed [31:0] avg_2;
    logic [31:0]        fused_var_0;
    logic [31:0]        fused_var_1;
    logic [31:0]        fused_var_2;
  } out_item_t;

  typedef enum logic [1:0] {
    DIV_RECIP,
    DIV_AVG,
    DIV_FUSE
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RECIP,
    ST_RECIP_WAIT,
    ST_CHECK,
    ST_AVG,
    ST_AVG_WAIT,
    ST_FUSE,
    ST_FUSE_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     acc_info;
    logic     store_avg;
    logic     store_fuse;
    logic     elem_clr;
    logic     elem_inc;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic elem_last;
    logic close;
    logic single;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

[rtl/core/window_downsample_inverse_variance_core.sv]
// window_downsample_inverse_variance_core: top level of the windowed fusion core
// Groups timestamped mean/variance vectors into windows of sample_period ticks and emits,
// per closed window, the truncated mean average and the inverse-variance fused variance.
// All division runs on one shared 49-step restoring divider: each item takes three
// reciprocal divisions, and an item that closes a multi-item window adds an average
// and a fusion division per element before the item is handed to the output register.
// One item is worked at a time; a finished result waits in the output register while
// the next item is taken.
`default_nettype none
module window_downsample_inverse_variance_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire wdiv_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output wdiv_pkg::out_item_t       out_item,
  input  wire logic                 cfg_we,
  input  wire logic [31:0]          cfg_wdata
);
  import wdiv_pkg::*;

  cmd_t    cmd;
  status_t status;

  wdiv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wdiv_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
`default_nettype wire

[rtl/core/wdiv_divider.sv]
// wdiv_divider: restoring divider, one quotient bit per cycle
`default_nettype none
module wdiv_divider (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [wdiv_pkg::QUO_W-1:0]  dividend,
  input  wire logic [wdiv_pkg::INFO_W-1:0] divisor,
  output logic                             done,
  output logic [wdiv_pkg::QUO_W-1:0]       quotient
);
  import wdiv_pkg::*;

  localparam int unsigned CNT_BITS = $clog2(QUO_W);
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(QUO_W - 1);

  logic                busy;
  logic [CNT_BITS-1:0] step;
  logic [QUO_W-1:0]    q;
  logic [INFO_W-1:0]   rem;
  logic [INFO_W-1:0]   dvs;
  logic [INFO_W:0]     trial;
  logic [INFO_W:0]     diff;
  logic                ge;

  always_comb begin
    trial = {rem, q[QUO_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      q   <= {q[QUO_W-2:0], ge};
      rem <= ge ? diff[INFO_W-1:0] : trial[INFO_W-1:0];
    end
  end

  assign quotient = q;

endmodule
`default_nettype wire

[rtl/core/wdiv_ctrl.sv]
// wdiv_ctrl: sequencer for accumulation, closing divisions and result hand-off
`default_nettype none
module wdiv_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire wdiv_pkg::status_t status,
  output wdiv_pkg::cmd_t         cmd
);
  import wdiv_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:       if (in_valid) state_next = ST_RECIP;
      ST_RECIP:      state_next = ST_RECIP_WAIT;
      ST_RECIP_WAIT: begin
        if (status.div_done) state_next = status.elem_last ? ST_CHECK : ST_RECIP;
      end
      ST_CHECK: begin
        if (!status.close) state_next = ST_IDLE;
        else if (status.single) state_next = ST_EMIT;
        else state_next = ST_AVG;
      end
      ST_AVG:        state_next = ST_AVG_WAIT;
      ST_AVG_WAIT:   if (status.div_done) state_next = ST_FUSE;
      ST_FUSE:       state_next = ST_FUSE_WAIT;
      ST_FUSE_WAIT: begin
        if (status.div_done) state_next = status.elem_last ? ST_EMIT : ST_AVG;
      end
      ST_EMIT:       if (status.out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.div_sel = DIV_RECIP;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load     = in_valid;
        cmd.elem_clr = in_valid;
      end
      ST_RECIP: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RECIP;
      end
      ST_RECIP_WAIT: begin
        cmd.acc_info = status.div_done;
        cmd.elem_inc = status.div_done && !status.elem_last;
      end
      ST_CHECK:      cmd.elem_clr = 1'b1;
      ST_AVG: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_AVG;
      end
      ST_AVG_WAIT:   cmd.store_avg = status.div_done;
      ST_FUSE: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_FUSE;
      end
      ST_FUSE_WAIT: begin
        cmd.store_fuse = status.div_done;
        cmd.elem_inc   = status.div_done && !status.elem_last;
      end
      ST_EMIT:       cmd.emit = status.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/wdiv_dp.sv]
// wdiv_dp: window state, sums, divider operand selection and output register
`default_nettype none
module wdiv_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire wdiv_pkg::in_item_t  in_item,
  input  wire logic                cfg_we,
  input  wire logic [31:0]         cfg_wdata,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output wdiv_pkg::out_item_t      out_item,
  input  wire wdiv_pkg::cmd_t      cmd,
  output wdiv_pkg::status_t        status
);
  import wdiv_pkg::*;

  logic [31:0]              sample_period;
  logic                     started;
  logic [31:0]              window_end;
  logic [CNT_W-1:0]         item_count;
  logic signed [SUM_W-1:0]  mean_sum [DIM];
  logic [INFO_W-1:0]        info_sum [DIM];
  in_item_t                 held;
  logic                     close;
  logic                     single;
  logic [ELEM_W-1:0]        elem;
  logic [31:0]              avg_res  [DIM];
  logic [31:0]              fvar_res [DIM];

  logic signed [31:0]       in_mean  [DIM];
  logic [31:0]              held_var [DIM];
  logic [32:0]              end_sum;
  logic [32:0]              adv_sum;
  logic [31:0]              end_first;
  logic [CNT_W-1:0]         count_next;
  logic [SUM_W-1:0]         mag;
  logic                     neg;
  logic [QUO_W-1:0]         dividend;
  logic [INFO_W-1:0]        divisor;
  logic                     div_done;
  logic [QUO_W-1:0]         quotient;
  logic [QUO_W-1:0]         recip;
  logic [INFO_W:0]          info_add;

  wdiv_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    in_mean[0]   = in_item.mean_0;
    in_mean[1]   = in_item.mean_1;
    in_mean[2]   = in_item.mean_2;
    held_var[0]  = held.var_0;
    held_var[1]  = held.var_1;
    held_var[2]  = held.var_2;
  end

  always_comb begin
    end_sum    = {1'b0, in_item.timestamp} + {1'b0, sample_period};
    end_first  = started ? window_end : (end_sum[32] ? MASK32 : end_sum[31:0]);
    adv_sum    = {1'b0, window_end} + {1'b0, sample_period};
    count_next = (item_count < MAX_WINDOW) ? item_count + 1'b1 : item_count;
    neg        = mean_sum[elem][SUM_W-1];
    mag        = neg ? SUM_W'(-mean_sum[elem]) : SUM_W'(mean_sum[elem]);
    recip      = (held_var[elem] == 32'd0) ? RECIP_SAT : quotient;
    info_add   = {1'b0, info_sum[elem]} + {{(INFO_W+1-QUO_W){1'b0}}, recip};
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_RECIP: begin
        dividend = ONE_Q48;
        divisor  = {32'd0, held_var[elem]};
      end
      DIV_AVG: begin
        dividend = {1'b0, mag};
        divisor  = {{(INFO_W-CNT_W){1'b0}}, item_count};
      end
      DIV_FUSE: begin
        dividend = ONE_Q48;
        divisor  = info_sum[elem];
      end
      default: begin
        dividend = ONE_Q48;
        divisor  = info_sum[elem];
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= PERIOD_RESET;
      started       <= 1'b0;
      window_end    <= '0;
      item_count    <= '0;
      out_valid     <= 1'b0;
      elem          <= '0;
      for (int i = 0; i < DIM; i++) begin
        mean_sum[i] <= '0;
        info_sum[i] <= '0;
      end
    end else begin
      if (cfg_we) sample_period <= cfg_wdata;
      if (cmd.elem_clr) elem <= '0;
      else if (cmd.elem_inc) elem <= elem + 1'b1;
      if (cmd.load) begin
        started    <= 1'b1;
        window_end <= end_first;
        item_count <= count_next;
        for (int i = 0; i < DIM; i++) begin
          mean_sum[i] <= mean_sum[i] + SUM_W'(in_mean[i]);
        end
      end
      if (cmd.acc_info) begin
        info_sum[elem] <= info_add[INFO_W] ? {INFO_W{1'b1}} : info_add[INFO_W-1:0];
      end
      if (cmd.emit) begin
        window_end <= adv_sum[32] ? MASK32 : adv_sum[31:0];
        item_count <= '0;
        for (int i = 0; i < DIM; i++) begin
          mean_sum[i] <= '0;
          info_sum[i] <= '0;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held   <= in_item;
      close  <= (in_item.timestamp >= end_first) || in_item.is_final_time ||
                (count_next >= MAX_WINDOW);
      single <= (count_next == CNT_W'(1));
    end
    if (cmd.store_avg) begin
      avg_res[elem] <= neg ? 32'(-quotient) : quotient[31:0];
    end
    if (cmd.store_fuse) begin
      fvar_res[elem] <= (quotient > {17'd0, MASK32}) ? MASK32 : quotient[31:0];
    end
    if (cmd.emit) begin
      out_item.out_timestamp <= held.timestamp;
      if (single) begin
        out_item.avg_0       <= held.mean_0;
        out_item.avg_1       <= held.mean_1;
        out_item.avg_2       <= held.mean_2;
        out_item.fused_var_0 <= held.var_0;
        out_item.fused_var_1 <= held.var_1;
        out_item.fused_var_2 <= held.var_2;
      end else begin
        out_item.avg_0       <= avg_res[0];
        out_item.avg_1       <= avg_res[1];
        out_item.avg_2       <= avg_res[2];
        out_item.fused_var_0 <= fvar_res[0];
        out_item.fused_var_1 <= fvar_res[1];
        out_item.fused_var_2 <= fvar_res[2];
      end
    end
  end

  always_comb begin
    status.div_done  = div_done;
    status.elem_last = (elem == ELEM_W'(DIM - 1));
    status.close     = close;
    status.single    = single;
    status.out_free  = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

[rtl/core/wdiv_checker.sv]
// wdiv_checker: port-level assertions for the windowed fusion core
`default_nettype none
module wdiv_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire wdiv_pkg::out_item_t out_item
);
  import wdiv_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // results come only out of the closing sequence
  a_emit_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

  // no result in the cycle right after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result without processing");

endmodule

bind window_downsample_inverse_variance_core wdiv_checker u_wdiv_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire
